/* rtl/efq_pkg.sv */
// Package for the quaternion to Euler angle block: payload structs, pipeline
// structs, widths and the CORDIC arctangent table.
// No dependencies.
`default_nettype none
package efq_pkg;

    localparam int CORDIC_STAGES = 16;
    localparam int SQRT_STEPS    = 16;
    localparam int LANE_W        = 36;
    localparam int ANG_W         = 34;
    localparam int TOL_W         = 10;
    localparam logic [TOL_W-1:0] TOL_RESET = 10'd16;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
    } in_t;

    typedef struct packed {
        logic signed [15:0] heading_angle;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] bank_angle;
        logic               gimbal_lock;
    } out_t;

    typedef struct packed {
        logic                     vld;
        logic                     lock;
        logic                     spos;
        logic signed [15:0]       s;
        logic signed [LANE_W-1:0] h_y;
        logic signed [LANE_W-1:0] h_x;
        logic signed [LANE_W-1:0] b_y;
        logic signed [LANE_W-1:0] b_x;
        logic [30:0]              rem;
        logic [30:0]              res;
    } sqrt_t;

    typedef struct packed {
        logic                     zero;
        logic signed [LANE_W-1:0] x;
        logic signed [LANE_W-1:0] y;
        logic signed [ANG_W-1:0]  z;
    } lane_t;

    typedef struct packed {
        logic  vld;
        logic  lock;
        logic  spos;
        lane_t h;
        lane_t p;
        lane_t b;
    } trio_t;

    function automatic logic signed [ANG_W-1:0] atan_val(input logic [4:0] idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            5'd0:  v = 34'sh020000000;
            5'd1:  v = 34'sh012E4051D;
            5'd2:  v = 34'sh009FB385B;
            5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43;
            5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E;
            5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53;
            5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98;
            5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6;
            5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh000000A2F9;
            5'd15: v = 34'sh00000517C;
            5'd16: v = 34'sh0000028BE;
            5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A2F;
            5'd19: v = 34'sh000000517;
            5'd20: v = 34'sh00000028B;
            5'd21: v = 34'sh000000145;
            5'd22: v = 34'sh0000000A2;
            5'd23: v = 34'sh000000051;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

/* rtl/efq_sqrt_cell.sv */
// One digit of the restoring integer square root, one result bit per cell.
// Depends on efq_pkg.
`default_nettype none
module efq_sqrt_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic [3:0]    step_idx,
    input  wire efq_pkg::sqrt_t din,
    output efq_pkg::sqrt_t     dout
);

    efq_pkg::sqrt_t cell_reg;
    efq_pkg::sqrt_t cell_next;
    logic [30:0]    bitv;
    logic [31:0]    trial;

    always_comb begin
        bitv      = 31'd1 << {step_idx, 1'b0};
        trial     = 32'(din.res) + 32'(bitv);
        cell_next = din;
        if (32'(din.rem) >= trial) begin
            cell_next.rem = 31'(32'(din.rem) - trial);
            cell_next.res = (din.res >> 1) + bitv;
        end else begin
            cell_next.res = din.res >> 1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (adv) begin
            cell_reg.vld <= din.vld;
        end
        if (adv) begin
            cell_reg.lock <= cell_next.lock;
            cell_reg.spos <= cell_next.spos;
            cell_reg.s    <= cell_next.s;
            cell_reg.h_y  <= cell_next.h_y;
            cell_reg.h_x  <= cell_next.h_x;
            cell_reg.b_y  <= cell_next.b_y;
            cell_reg.b_x  <= cell_next.b_x;
            cell_reg.rem  <= cell_next.rem;
            cell_reg.res  <= cell_next.res;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

/* rtl/efq_cordic_cell.sv */
// One vectoring CORDIC micro-rotation for the heading, pitch and bank lanes.
// Depends on efq_pkg.
`default_nettype none
module efq_cordic_cell (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          adv,
    input  wire logic [4:0]    step_idx,
    input  wire efq_pkg::trio_t din,
    output efq_pkg::trio_t     dout
);

    efq_pkg::trio_t cell_reg;
    efq_pkg::trio_t cell_next;

    function automatic efq_pkg::lane_t rot(input efq_pkg::lane_t a, input logic [4:0] i);
        efq_pkg::lane_t r;
        logic signed [efq_pkg::LANE_W-1:0] dx;
        logic signed [efq_pkg::LANE_W-1:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        r  = a;
        if (!a.y[efq_pkg::LANE_W-1]) begin
            r.x = a.x + dx;
            r.y = a.y - dy;
            r.z = a.z + efq_pkg::atan_val(i);
        end else begin
            r.x = a.x - dx;
            r.y = a.y + dy;
            r.z = a.z - efq_pkg::atan_val(i);
        end
        return r;
    endfunction

    always_comb begin
        cell_next   = din;
        cell_next.h = rot(din.h, step_idx);
        cell_next.p = rot(din.p, step_idx);
        cell_next.b = rot(din.b, step_idx);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (adv) begin
            cell_reg.vld <= din.vld;
        end
        if (adv) begin
            cell_reg.lock <= cell_next.lock;
            cell_reg.spos <= cell_next.spos;
            cell_reg.h    <= cell_next.h;
            cell_reg.p    <= cell_next.p;
            cell_reg.b    <= cell_next.b;
        end
    end

    assign dout = cell_reg;

endmodule
`default_nettype wire

/* rtl/euler_from_quaternion.sv */
// Top level: quaternion in Q2.14 to heading, pitch and bank binary angles.
// Depends on efq_pkg, efq_sqrt_cell and efq_cordic_cell.
//
// A request on s_valid/s_ready/s_data carries one quaternion (w,x,y,z).
// m_valid/m_ready/m_data returns heading, pitch, bank and the gimbal-lock
// flag for it, in request order, one result per request.
// cfg_we/cfg_wdata write lock_tolerance (reset value 16).
// m_valid rises after the input register, which loads at the accepting edge,
// then products, pitch sine, square of the sine, one square-root bit per
// cell over 16 cells, pre-rotation, one CORDIC micro-rotation per cell and
// the output register. Throughput is one request per cycle while the skid
// register is empty: every stage is a register.
// When m_ready is low, one more result lands in a skid register; s_ready
// then drops and the whole chain holds until the skid drains.
// Reset empties the chain and the output; lock_tolerance returns to 16.
`default_nettype none
module euler_from_quaternion (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire efq_pkg::in_t                s_data,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output efq_pkg::out_t                    m_data,
    input  wire logic                        cfg_we,
    input  wire logic [efq_pkg::TOL_W-1:0]   cfg_wdata
);

    localparam int LW = efq_pkg::LANE_W;
    localparam int AW = efq_pkg::ANG_W;

    logic [efq_pkg::TOL_W-1:0] tol_reg;
    logic                      adv;

    efq_pkg::in_t q_reg;
    logic         q_vld_reg;

    logic signed [31:0] wx_reg, yz_reg, wy_reg, xz_reg, xy_reg, wz_reg;
    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    logic               p_vld_reg;

    logic signed [32:0] sdiff;
    logic signed [34:0] sround;
    logic signed [20:0] sshift;
    logic signed [15:0] s_sat;
    logic signed [16:0] tol_s;
    logic               lock_c;
    logic signed [LW-1:0] half;

    logic signed [15:0]   s_reg;
    logic                 lock_reg, spos_reg, s_vld_reg;
    logic signed [LW-1:0] hy_reg, hx_reg, by_reg, bx_reg;

    logic signed [31:0] sq;

    efq_pkg::sqrt_t sqrt_pipe [efq_pkg::SQRT_STEPS+1];
    efq_pkg::sqrt_t sqrt_head_reg;
    efq_pkg::trio_t trio_pipe [efq_pkg::CORDIC_STAGES+1];
    efq_pkg::trio_t prep_reg;
    efq_pkg::trio_t prep_next;
    efq_pkg::sqrt_t sq_tail;

    efq_pkg::trio_t fin;
    efq_pkg::out_t  res_c;
    logic           inc;
    logic signed [17:0] ang_h, ang_p, ang_b;
    logic signed [15:0] pitch_c;

    efq_pkg::out_t out_reg, skid_reg;
    logic          out_vld_reg, skid_vld_reg;

    function automatic efq_pkg::lane_t prerot(input logic signed [LW-1:0] y,
                                              input logic signed [LW-1:0] x);
        efq_pkg::lane_t r;
        r.zero = (x == '0) && (y == '0);
        r.x    = x;
        r.y    = y;
        r.z    = '0;
        if (x[LW-1]) begin
            if (!y[LW-1]) begin
                r.x = y;
                r.y = -x;
                r.z = AW'(34'sh040000000);
            end else begin
                r.x = -y;
                r.y = x;
                r.z = -AW'(34'sh040000000);
            end
        end
        return r;
    endfunction

    function automatic logic signed [17:0] binang(input efq_pkg::lane_t a);
        logic signed [AW-1:0] zr;
        zr = a.z + AW'(32768);
        return a.zero ? 18'sd0 : 18'(zr >>> 16);
    endfunction

    assign adv     = !skid_vld_reg;
    assign s_ready = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= efq_pkg::TOL_RESET;
        end else if (cfg_we) begin
            tol_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
            p_vld_reg <= 1'b0;
            s_vld_reg <= 1'b0;
        end else if (adv) begin
            q_vld_reg <= s_valid;
            p_vld_reg <= q_vld_reg;
            s_vld_reg <= p_vld_reg;
        end
        if (adv) begin
            q_reg  <= s_data;
            wx_reg <= q_reg.quat_w * q_reg.quat_x;
            yz_reg <= q_reg.quat_y * q_reg.quat_z;
            wy_reg <= q_reg.quat_w * q_reg.quat_y;
            xz_reg <= q_reg.quat_x * q_reg.quat_z;
            xy_reg <= q_reg.quat_x * q_reg.quat_y;
            wz_reg <= q_reg.quat_w * q_reg.quat_z;
            xx_reg <= q_reg.quat_x * q_reg.quat_x;
            yy_reg <= q_reg.quat_y * q_reg.quat_y;
            zz_reg <= q_reg.quat_z * q_reg.quat_z;
        end
    end

    always_comb begin
        half   = LW'(134217728);
        sdiff  = 33'(wx_reg) - 33'(yz_reg);
        sround = (35'(sdiff) <<< 1) + 35'sd8192;
        sshift = 21'(sround >>> 14);
        if (sshift > 21'sd16384) begin
            s_sat = 16'sd16384;
        end else if (sshift < -21'sd16384) begin
            s_sat = -16'sd16384;
        end else begin
            s_sat = 16'(sshift);
        end
        tol_s  = signed'(17'(tol_reg));
        lock_c = (17'(s_sat) >= 17'sd16384 - tol_s) || (17'(s_sat) <= -17'sd16384 + tol_s);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s_reg    <= s_sat;
            lock_reg <= lock_c;
            spos_reg <= s_sat > 16'sd0;
            if (lock_c) begin
                hy_reg <= LW'(wy_reg) - LW'(xz_reg);
                hx_reg <= half - LW'(yy_reg) - LW'(zz_reg);
            end else begin
                hy_reg <= LW'(xz_reg) + LW'(wy_reg);
                hx_reg <= half - LW'(xx_reg) - LW'(yy_reg);
            end
            by_reg <= LW'(xy_reg) + LW'(wz_reg);
            bx_reg <= half - LW'(xx_reg) - LW'(zz_reg);
        end
    end

    assign sq = s_reg * s_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sqrt_head_reg.vld <= 1'b0;
        end else if (adv) begin
            sqrt_head_reg.vld <= s_vld_reg;
        end
        if (adv) begin
            sqrt_head_reg.lock <= lock_reg;
            sqrt_head_reg.spos <= spos_reg;
            sqrt_head_reg.s    <= s_reg;
            sqrt_head_reg.h_y  <= hy_reg;
            sqrt_head_reg.h_x  <= hx_reg;
            sqrt_head_reg.b_y  <= by_reg;
            sqrt_head_reg.b_x  <= bx_reg;
            sqrt_head_reg.rem  <= 31'(32'sd268435456 - sq);
            sqrt_head_reg.res  <= '0;
        end
    end

    assign sqrt_pipe[0] = sqrt_head_reg;

    for (genvar i = 0; i < efq_pkg::SQRT_STEPS; i++) begin : g_sqrt
        efq_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .step_idx (4'(efq_pkg::SQRT_STEPS - 1 - i)),
            .din      (sqrt_pipe[i]),
            .dout     (sqrt_pipe[i+1])
        );
    end

    assign sq_tail = sqrt_pipe[efq_pkg::SQRT_STEPS];

    always_comb begin
        prep_next.vld  = sq_tail.vld;
        prep_next.lock = sq_tail.lock;
        prep_next.spos = sq_tail.spos;
        prep_next.h    = prerot(sq_tail.h_y, sq_tail.h_x);
        prep_next.p    = prerot(LW'(sq_tail.s) <<< 14, signed'(LW'(sq_tail.res)) <<< 14);
        prep_next.b    = prerot(sq_tail.b_y, sq_tail.b_x);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_reg.vld <= 1'b0;
        end else if (adv) begin
            prep_reg.vld <= prep_next.vld;
        end
        if (adv) begin
            prep_reg.lock <= prep_next.lock;
            prep_reg.spos <= prep_next.spos;
            prep_reg.h    <= prep_next.h;
            prep_reg.p    <= prep_next.p;
            prep_reg.b    <= prep_next.b;
        end
    end

    assign trio_pipe[0] = prep_reg;

    for (genvar i = 0; i < efq_pkg::CORDIC_STAGES; i++) begin : g_cordic
        efq_cordic_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .step_idx (5'(i)),
            .din      (trio_pipe[i]),
            .dout     (trio_pipe[i+1])
        );
    end

    assign fin = trio_pipe[efq_pkg::CORDIC_STAGES];

    always_comb begin
        ang_h = binang(fin.h);
        ang_p = binang(fin.p);
        ang_b = binang(fin.b);
        if (ang_p > 18'sd16384) begin
            pitch_c = 16'sd16384;
        end else if (ang_p < -18'sd16384) begin
            pitch_c = -16'sd16384;
        end else begin
            pitch_c = 16'(ang_p);
        end
        res_c.heading_angle = 16'(ang_h);
        res_c.gimbal_lock   = fin.lock;
        if (fin.lock) begin
            res_c.pitch_angle = fin.spos ? 16'sd16384 : -16'sd16384;
            res_c.bank_angle  = 16'sd0;
        end else begin
            res_c.pitch_angle = pitch_c;
            res_c.bank_angle  = 16'(ang_b);
        end
        inc = fin.vld && adv;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            if (skid_vld_reg) begin
                out_vld_reg  <= 1'b1;
                skid_vld_reg <= 1'b0;
            end else begin
                out_vld_reg <= inc;
            end
        end else if (inc) begin
            skid_vld_reg <= 1'b1;
        end
        if (!out_vld_reg || m_ready) begin
            out_reg <= skid_vld_reg ? skid_reg : res_c;
        end else if (inc) begin
            skid_reg <= res_c;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

    assert property (@(posedge aclk) disable iff (!aresetn) skid_vld_reg |-> out_vld_reg)
        else $error("skid holds a result while output is empty");

    assert property (@(posedge aclk) !aresetn |=> !m_valid && s_ready)
        else $error("chain not empty after reset");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.gimbal_lock |->
            m_data.bank_angle == 16'sd0 &&
            (m_data.pitch_angle == 16'sd16384 || m_data.pitch_angle == -16'sd16384))
        else $error("locked result with bank or pitch off");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && inc |=> skid_vld_reg && !s_ready)
        else $error("stalled result not captured in skid");

endmodule
`default_nettype wire
